/* hdl/segx_pkg.sv */
// shared widths and types for the segment intersection core
package segx_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int DEN_W      = 2 * COORD_BITS + 3;
    localparam int PROD_W     = DEN_W + DIFF_W;
    localparam int NUM_W      = PROD_W + 2;
    localparam int QUO_W      = COORD_BITS + 1;

    // payload handed from cell to cell in the divider chain
    typedef struct packed {
        logic                  hit;
        logic                  neg_x;
        logic                  neg_y;
        logic [COORD_BITS-1:0] ax0;
        logic [COORD_BITS-1:0] ay0;
        logic [NUM_W-1:0]      rx;
        logic [NUM_W-1:0]      ry;
        logic [NUM_W-1:0]      d;
        logic [QUO_W-1:0]      qx;
        logic [QUO_W-1:0]      qy;
    } div_t;

endpackage

/* hdl/seg_if.sv */
// valid/ready channels for segment pairs and intersection results
interface seg_in_if
    import segx_pkg::*;
    ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_start_x;
    logic signed [COORD_BITS-1:0] a_start_y;
    logic signed [COORD_BITS-1:0] a_end_x;
    logic signed [COORD_BITS-1:0] a_end_y;
    logic signed [COORD_BITS-1:0] b_start_x;
    logic signed [COORD_BITS-1:0] b_start_y;
    logic signed [COORD_BITS-1:0] b_end_x;
    logic signed [COORD_BITS-1:0] b_end_y;

    modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                    b_start_x, b_start_y, b_end_x, b_end_y, input ready);
    modport sink   (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                    b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface seg_out_if
    import segx_pkg::*;
    ();
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic signed [COORD_BITS-1:0] cross_x;
    logic signed [COORD_BITS-1:0] cross_y;

    modport source (output valid, hit, cross_x, cross_y, input ready);
    modport sink   (input valid, hit, cross_x, cross_y, output ready);
endinterface

/* hdl/segx_front.sv */
// setup pipeline: directions, cross products, hit test, dividend and divisor
module segx_front
    import segx_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] ax0,
    input  logic signed [COORD_BITS-1:0] ay0,
    input  logic signed [COORD_BITS-1:0] ax1,
    input  logic signed [COORD_BITS-1:0] ay1,
    input  logic signed [COORD_BITS-1:0] bx0,
    input  logic signed [COORD_BITS-1:0] by0,
    input  logic signed [COORD_BITS-1:0] bx1,
    input  logic signed [COORD_BITS-1:0] by1,
    output logic                         out_valid,
    input  logic                         out_ready,
    output div_t                         out_data
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    // per-stage advance, bubbles collapse
    assign adv4     = !v4_reg || out_ready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // stage 1: differences and the three cross products
    logic signed [DIFF_W-1:0]   s1x, s1y, s2x, s2y, dx, dy;
    logic signed [2*DIFF_W-1:0] p0, p1, p2, p3, p4, p5;
    logic signed [DEN_W-1:0]    den_next, sn_next, tn_next;

    always_comb
    begin
        s1x = DIFF_W'(ax1) - DIFF_W'(ax0);
        s1y = DIFF_W'(ay1) - DIFF_W'(ay0);
        s2x = DIFF_W'(bx1) - DIFF_W'(bx0);
        s2y = DIFF_W'(by1) - DIFF_W'(by0);
        dx  = DIFF_W'(ax0) - DIFF_W'(bx0);
        dy  = DIFF_W'(ay0) - DIFF_W'(by0);
        p0  = s1x * s2y;
        p1  = s2x * s1y;
        p2  = s1x * dy;
        p3  = s1y * dx;
        p4  = s2x * dy;
        p5  = s2y * dx;
        den_next = DEN_W'(p0) - DEN_W'(p1);
        sn_next  = DEN_W'(p2) - DEN_W'(p3);
        tn_next  = DEN_W'(p4) - DEN_W'(p5);
    end

    logic signed [DEN_W-1:0]      den1_reg, sn1_reg, tn1_reg;
    logic signed [DIFF_W-1:0]     s1x1_reg, s1y1_reg;
    logic signed [COORD_BITS-1:0] ax1_reg, ay1_reg;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            den1_reg <= den_next;
            sn1_reg  <= sn_next;
            tn1_reg  <= tn_next;
            s1x1_reg <= s1x;
            s1y1_reg <= s1y;
            ax1_reg  <= ax0;
            ay1_reg  <= ay0;
        end
    end

    // stage 2: bring to the denominator's sign and test both parameters
    logic signed [DEN_W-1:0] den_n, sn_n, tn_n;
    logic                    hit_next;

    always_comb
    begin
        if (den1_reg < 0)
        begin
            den_n = -den1_reg;
            sn_n  = -sn1_reg;
            tn_n  = -tn1_reg;
        end
        else
        begin
            den_n = den1_reg;
            sn_n  = sn1_reg;
            tn_n  = tn1_reg;
        end
        hit_next = (den1_reg != '0) && (sn_n >= 0) && (sn_n <= den_n)
                   && (tn_n >= 0) && (tn_n <= den_n);
    end

    logic                         hit2_reg;
    logic signed [DEN_W-1:0]      den2_reg, tn2_reg;
    logic signed [DIFF_W-1:0]     s1x2_reg, s1y2_reg;
    logic signed [COORD_BITS-1:0] ax2_reg, ay2_reg;

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            hit2_reg <= hit_next;
            den2_reg <= den_n;
            tn2_reg  <= tn_n;
            s1x2_reg <= s1x1_reg;
            s1y2_reg <= s1y1_reg;
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
        end
    end

    // stage 3: scale both directions by the t numerator
    logic signed [PROD_W-1:0] px_next, py_next;

    assign px_next = tn2_reg * s1x2_reg;
    assign py_next = tn2_reg * s1y2_reg;

    logic                         hit3_reg;
    logic signed [DEN_W-1:0]      den3_reg;
    logic signed [PROD_W-1:0]     px3_reg, py3_reg;
    logic signed [COORD_BITS-1:0] ax3_reg, ay3_reg;

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            hit3_reg <= hit2_reg;
            den3_reg <= den2_reg;
            px3_reg  <= px_next;
            py3_reg  <= py_next;
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
        end
    end

    // stage 4: magnitudes and rounding offset, 2|n|+den over 2*den
    logic [PROD_W-1:0] magx, magy;
    div_t              d4_next;

    always_comb
    begin
        magx = (px3_reg < 0) ? PROD_W'(-px3_reg) : PROD_W'(px3_reg);
        magy = (py3_reg < 0) ? PROD_W'(-py3_reg) : PROD_W'(py3_reg);
        d4_next.hit   = hit3_reg;
        d4_next.neg_x = px3_reg < 0;
        d4_next.neg_y = py3_reg < 0;
        d4_next.ax0   = ax3_reg;
        d4_next.ay0   = ay3_reg;
        d4_next.rx    = NUM_W'({magx, 1'b0}) + NUM_W'(unsigned'(den3_reg));
        d4_next.ry    = NUM_W'({magy, 1'b0}) + NUM_W'(unsigned'(den3_reg));
        d4_next.d     = NUM_W'({unsigned'(den3_reg), 1'b0});
        d4_next.qx    = '0;
        d4_next.qy    = '0;
    end

    div_t d4_reg;

    always_ff @(posedge clk)
    begin
        if (adv4) d4_reg <= d4_next;
    end

    assign out_valid = v4_reg;
    assign out_data  = d4_reg;

endmodule

/* hdl/segx_div_cell.sv */
// one restoring-division cell: settles one quotient bit for both axes
module segx_div_cell
    import segx_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  div_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output div_t out_data
);

    logic       v_reg;
    div_t       d_reg;
    div_t       d_next;
    logic [NUM_W-1:0] dsh;

    assign in_ready = !v_reg || out_ready;

    // trial subtract of the shifted divisor
    always_comb
    begin
        dsh    = in_data.d << IDX;
        d_next = in_data;
        if (in_data.rx >= dsh)
        begin
            d_next.rx      = in_data.rx - dsh;
            d_next.qx[IDX] = 1'b1;
        end
        if (in_data.ry >= dsh)
        begin
            d_next.ry      = in_data.ry - dsh;
            d_next.qy[IDX] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready) d_reg <= d_next;
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

/* hdl/segment_intersection_core.sv */
// segment intersection core: setup stages, divider cell chain, output register
// stages: 4 setup + 17 divider cells + 1 output register, each registered
// throughput: one pair per cycle unless stalled; every stage is fully pipelined
// the divider chain settles one quotient bit per cell, which sets the latency
// stalls collapse bubbles stage by stage; ready follows the chain back
// reset (async, active low) clears all valid bits; payload is not reset
module segment_intersection_core
    import segx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    seg_in_if.sink      pair,
    seg_out_if.source   result
);

    logic cv  [QUO_W+1];
    logic cr  [QUO_W+1];
    div_t cd  [QUO_W+1];

    segx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pair.valid),
        .in_ready  (pair.ready),
        .ax0       (pair.a_start_x),
        .ay0       (pair.a_start_y),
        .ax1       (pair.a_end_x),
        .ay1       (pair.a_end_y),
        .bx0       (pair.b_start_x),
        .by0       (pair.b_start_y),
        .bx1       (pair.b_end_x),
        .by1       (pair.b_end_y),
        .out_valid (cv[0]),
        .out_ready (cr[0]),
        .out_data  (cd[0])
    );

    // divider chain, most significant quotient bit first
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_cell
        segx_div_cell #(.IDX(QUO_W - 1 - k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cv[k]),
            .in_ready  (cr[k]),
            .in_data   (cd[k]),
            .out_valid (cv[k+1]),
            .out_ready (cr[k+1]),
            .out_data  (cd[k+1])
        );
    end

    // output register: restore sign, add start point, zero on miss
    logic                  ov_reg;
    logic                  hit_reg;
    logic [COORD_BITS-1:0] cx_reg, cy_reg;
    logic [COORD_BITS-1:0] qx, qy, cx_next, cy_next;
    div_t                  fin;

    assign fin       = cd[QUO_W];
    assign cr[QUO_W] = !ov_reg || result.ready;

    always_comb
    begin
        qx = fin.qx[COORD_BITS-1:0];
        qy = fin.qy[COORD_BITS-1:0];
        if (fin.neg_x) qx = -qx;
        if (fin.neg_y) qy = -qy;
        cx_next = fin.hit ? fin.ax0 + qx : '0;
        cy_next = fin.hit ? fin.ay0 + qy : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cr[QUO_W])
            ov_reg <= cv[QUO_W];
    end

    always_ff @(posedge clk)
    begin
        if (cr[QUO_W])
        begin
            hit_reg <= fin.hit;
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
        end
    end

    assign result.valid   = ov_reg;
    assign result.hit     = hit_reg;
    assign result.cross_x = cx_reg;
    assign result.cross_y = cy_reg;

endmodule

/* hdl/segx_chk.sv */
// port-level checks for the segment intersection core
module segx_chk
    import segx_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  out_hit,
    input logic [COORD_BITS-1:0] out_x,
    input logic [COORD_BITS-1:0] out_y
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_hit)
            && $stable(out_x) && $stable(out_y))
        else $error("stalled result changed");

    // a miss reports the origin
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_hit |-> out_x == '0 && out_y == '0)
        else $error("miss with nonzero point");

    // reset empties the output register
    a_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // with the output empty the whole pipeline can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

endmodule

bind segment_intersection_core segx_chk u_segx_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (pair.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_hit   (result.hit),
    .out_x     (result.cross_x),
    .out_y     (result.cross_y)
);

/* bench/segment_intersection_core_tb.sv */
// testbench for the segment intersection core: random and corner pairs checked by a scoreboard
module segment_intersection_core_tb;
    import segx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PAIRS = 540;
    localparam int PIPE_DEPTH = 22;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct {
        coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    } seg_pair_t;

    typedef struct {
        logic   hit;
        coord_t cx;
        coord_t cy;
    } crossing_t;

    // exact intersection predictor and queue of pending crossings
    class crossing_board;
        crossing_t pending[$];
        int mismatches;
        int checked;
        int hits_seen;

        function automatic logic signed [127:0] round_quot(logic signed [127:0] num,
                                                           logic signed [127:0] den);
            logic signed [127:0] mag;
            logic signed [127:0] q;
            mag = (num < 0) ? -num : num;
            q = (2 * mag + den) / (2 * den);
            return (num < 0) ? -q : q;
        endfunction

        function automatic crossing_t predict(seg_pair_t p);
            logic signed [127:0] s1x, s1y, s2x, s2y, dx, dy, den, sn, tn, px, py;
            crossing_t c;
            s1x = 128'(p.ax1) - 128'(p.ax0);
            s1y = 128'(p.ay1) - 128'(p.ay0);
            s2x = 128'(p.bx1) - 128'(p.bx0);
            s2y = 128'(p.by1) - 128'(p.by0);
            dx = 128'(p.ax0) - 128'(p.bx0);
            dy = 128'(p.ay0) - 128'(p.by0);
            den = s1x * s2y - s2x * s1y;
            sn = s1x * dy - s1y * dx;
            tn = s2x * dy - s2y * dx;
            c.hit = 1'b0;
            c.cx = '0;
            c.cy = '0;
            if (den != 0)
            begin
                if (den < 0)
                begin
                    den = -den;
                    sn = -sn;
                    tn = -tn;
                end
                if (sn >= 0 && sn <= den && tn >= 0 && tn <= den)
                begin
                    px = 128'(p.ax0) + round_quot(tn * s1x, den);
                    py = 128'(p.ay0) + round_quot(tn * s1y, den);
                    c.hit = 1'b1;
                    c.cx = px[COORD_BITS-1:0];
                    c.cy = py[COORD_BITS-1:0];
                end
            end
            return c;
        endfunction

        function void note_pair(seg_pair_t p);
            pending.push_back(predict(p));
        endfunction

        function void check_result(logic hit, coord_t cx, coord_t cy);
            crossing_t e;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: hit=%0b x=%0d y=%0d", hit, cx, cy);
                return;
            end
            e = pending.pop_front();
            if (hit)
                hits_seen++;
            if (hit !== e.hit || cx !== e.cx || cy !== e.cy)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                             checked, e.hit, e.cx, e.cy, hit, cx, cy);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    seg_in_if  pair_ch();
    seg_out_if result_ch();

    crossing_board board;
    int  cycles;
    bit  calm;         // no idling in the last part of the run
    bit  long_hold;    // receiver holds off for a long stretch
    bit  feed_done;

    segment_intersection_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair_ch.sink),
        .result (result_ch.source)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("segment_intersection_core_tb: done, errors");
            $finish;
        end
    end

    // sample accepted beats on both channels
    always @(posedge clk)
    begin
        if (rst_n && pair_ch.valid && pair_ch.ready)
            board.note_pair('{pair_ch.a_start_x, pair_ch.a_start_y, pair_ch.a_end_x,
                              pair_ch.a_end_y, pair_ch.b_start_x, pair_ch.b_start_y,
                              pair_ch.b_end_x, pair_ch.b_end_y});
        if (rst_n && result_ch.valid && result_ch.ready)
            board.check_result(result_ch.hit, result_ch.cross_x, result_ch.cross_y);
    end

    // receiver: random stall bursts, one long hold-off
    initial
    begin
        int gap;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                result_ch.ready <= 1'b0;
                repeat (80) @(negedge clk);
                long_hold = 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 11);
                result_ch.ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 2047)) - coord_t'(1024);
            default: return coord_t'($urandom_range(0, 127)) - coord_t'(64);
        endcase
    endfunction

    // a random pair; often a crossing shape so hits are frequent
    function automatic seg_pair_t rand_pair();
        seg_pair_t p;
        int mode;
        int shape;
        mode = $urandom_range(0, 2);
        shape = $urandom_range(0, 9);
        p.ax0 = rand_coord(mode);
        p.ay0 = rand_coord(mode);
        p.bx0 = rand_coord(mode);
        p.by0 = rand_coord(mode);
        if (mode != 0 && shape < 6)
        begin
            // mirror each end about the other segment's start to force a crossing
            p.ax1 = coord_t'(2 * p.bx0 - p.ax0 + rand_coord(2));
            p.ay1 = coord_t'(2 * p.by0 - p.ay0 + rand_coord(2));
            p.bx1 = coord_t'(2 * p.ax0 - p.bx0 + rand_coord(2));
            p.by1 = coord_t'(2 * p.ay0 - p.by0 + rand_coord(2));
            p.bx0 = coord_t'((p.ax0 + p.ax1) / 2 + (p.bx0 - p.bx1) / 2);
            p.by0 = coord_t'((p.ay0 + p.ay1) / 2 + (p.by0 - p.by1) / 2);
        end
        else if (shape == 6)
        begin
            // parallel pair
            p.ax1 = p.ax0 + rand_coord(2);
            p.ay1 = p.ay0 + rand_coord(2);
            p.bx1 = p.bx0 + (p.ax1 - p.ax0);
            p.by1 = p.by0 + (p.ay1 - p.ay0);
        end
        else
        begin
            p.ax1 = rand_coord(mode);
            p.ay1 = rand_coord(mode);
            p.bx1 = rand_coord(mode);
            p.by1 = rand_coord(mode);
        end
        return p;
    endfunction

    task automatic send_pair(seg_pair_t p);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            pair_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pair_ch.valid     <= 1'b1;
        pair_ch.a_start_x <= p.ax0;
        pair_ch.a_start_y <= p.ay0;
        pair_ch.a_end_x   <= p.ax1;
        pair_ch.a_end_y   <= p.ay1;
        pair_ch.b_start_x <= p.bx0;
        pair_ch.b_start_y <= p.by0;
        pair_ch.b_end_x   <= p.bx1;
        pair_ch.b_end_y   <= p.by1;
        do
            @(posedge clk);
        while (!pair_ch.ready);
        @(negedge clk);
    endtask

    function automatic seg_pair_t mk(int a, int b, int c, int d, int e, int f, int g, int h);
        seg_pair_t p;
        p = '{coord_t'(a), coord_t'(b), coord_t'(c), coord_t'(d),
              coord_t'(e), coord_t'(f), coord_t'(g), coord_t'(h)};
        return p;
    endfunction

    // stimulus and end of run
    initial
    begin
        seg_pair_t corners[$];
        int drain;
        board = new();
        cycles = 0;
        calm = 1'b0;
        long_hold = 1'b0;
        feed_done = 1'b0;
        rst_n = 1'b0;
        pair_ch.valid = 1'b0;
        {pair_ch.a_start_x, pair_ch.a_start_y, pair_ch.a_end_x, pair_ch.a_end_y} = '0;
        {pair_ch.b_start_x, pair_ch.b_start_y, pair_ch.b_end_x, pair_ch.b_end_y} = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: plain cross, end-point touches, parallel, collinear, extremes
        corners.push_back(mk(0, 0, 160, 160, 0, 160, 160, 0));
        corners.push_back(mk(0, 0, 160, 0, 160, 0, 160, 160));
        corners.push_back(mk(0, 0, 160, 0, 0, 0, 0, 160));
        corners.push_back(mk(0, 0, 160, 0, 0, 16, 160, 16));
        corners.push_back(mk(0, 0, 160, 0, 32, 0, 320, 0));
        corners.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
        corners.push_back(mk(0, 0, 10, 0, 20, -5, 20, 5));
        corners.push_back(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        corners.push_back(mk(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
        corners.push_back(mk(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
        corners.push_back(mk(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
        corners.push_back(mk(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767));
        corners.push_back(mk(0, 0, 3, 1, 1, 0, 0, 1));
        corners.push_back(mk(0, 0, -3, -1, -1, 0, 0, -1));
        corners.push_back(mk(0, 0, 1, 2, 0, 1, 1, 0));
        corners.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1));
        corners.push_back(mk(-21846, 21845, 21845, -21846, 21845, 21845, -21846, -21846));
        foreach (corners[i])
            send_pair(corners[i]);

        // random pairs, one long receiver hold-off early on
        for (int n = 0; n < RANDOM_PAIRS; n++)
        begin
            if (n == 40)
                long_hold = 1'b1;
            if (n == RANDOM_PAIRS - 100)
                calm = 1'b1;
            send_pair(rand_pair());
        end
        pair_ch.valid <= 1'b0;
        feed_done = 1'b1;

        while (board.pending.size() != 0)
            @(negedge clk);
        drain = 0;
        while (drain < 2 * PIPE_DEPTH)
        begin
            @(negedge clk);
            drain++;
        end

        $display("checked %0d results across %0d directed and random pairs, %0d hits",
                 board.checked, corners.size() + RANDOM_PAIRS, board.hits_seen);
        if (board.mismatches == 0)
            $display("segment_intersection_core_tb: done, clean");
        else
        begin
            $display("%0d mismatches", board.mismatches);
            $display("segment_intersection_core_tb: done, errors");
        end
        $finish;
    end

endmodule
